>>> rtl/bgdc_pkg.sv
// Shared types, constants and functions for the button gesture digit counter.
package bgdc_pkg;

  localparam int TimeW = 12;
  localparam int CfgTimeW = 12;
  localparam int CmpW = (TimeW > CfgTimeW) ? TimeW : CfgTimeW;
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int DigitW = 4;
  localparam int SegW = 7;

  typedef logic [TimeW-1:0] time_t;
  typedef logic [CfgTimeW-1:0] cfg_time_t;
  typedef logic [CmpW-1:0] cmp_t;
  typedef logic [DigitW-1:0] digit_t;
  typedef logic [SegW-1:0] seg_t;

  typedef enum logic [2:0] {
    RegDebounce    = 3'd0,
    RegDoubleClick = 3'd1,
    RegLongPress   = 3'd2,
    RegRepeat      = 3'd3,
    RegCommonAnode = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ChgNone     = 2'd0,
    ChgPlusOne  = 2'd1,
    ChgPlusTwo  = 2'd2,
    ChgMinusOne = 2'd3
  } change_e;

  typedef struct packed {
    cfg_time_t debounce_ticks;
    cfg_time_t double_click_ticks;
    cfg_time_t long_press_ticks;
    cfg_time_t repeat_ticks;
    logic      common_anode;
  } cfg_t;

  typedef struct packed {
    digit_t  digit;
    seg_t    seg;
    change_e code;
  } res_t;

  function automatic time_t sat_inc(input time_t v);
    return (v == '1) ? v : v + time_t'(1);
  endfunction

  function automatic digit_t digit_up(input digit_t d);
    return (d >= digit_t'(9)) ? digit_t'(0) : d + digit_t'(1);
  endfunction

  function automatic digit_t digit_down(input digit_t d);
    return (d == digit_t'(0) || d > digit_t'(9)) ? digit_t'(9) : d - digit_t'(1);
  endfunction

  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      digit_t'(1): s = 7'h06;
      digit_t'(2): s = 7'h5B;
      digit_t'(3): s = 7'h4F;
      digit_t'(4): s = 7'h66;
      digit_t'(5): s = 7'h6D;
      digit_t'(6): s = 7'h7D;
      digit_t'(7): s = 7'h07;
      digit_t'(8): s = 7'h7F;
      digit_t'(9): s = 7'h6F;
      default:     s = 7'h3F;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/bgdc_engine.sv
// Debounce, click, double-click and long-press state with the digit update for one tick.
module bgdc_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           raw_i,
  input  bgdc_pkg::cfg_t cfg_i,
  output bgdc_pkg::res_t res_o
);

  logic prev_q, prev_d;
  logic stable_q, stable_d;
  logic long_q, long_d;
  logic pending_q, pending_d;
  bgdc_pkg::time_t steady_q, steady_d;
  bgdc_pkg::time_t hold_q, hold_d;
  bgdc_pkg::time_t rep_q, rep_d;
  bgdc_pkg::time_t pend_q, pend_d;
  bgdc_pkg::digit_t digit_q, digit_d;
  logic [1:0] ups;
  logic down;

  always_comb begin
    prev_d    = prev_q;
    stable_d  = stable_q;
    long_d    = long_q;
    pending_d = pending_q;
    steady_d  = steady_q;
    hold_d    = bgdc_pkg::sat_inc(hold_q);
    rep_d     = bgdc_pkg::sat_inc(rep_q);
    pend_d    = bgdc_pkg::sat_inc(pend_q);
    digit_d   = digit_q;
    ups       = 2'd0;
    down      = 1'b0;

    if (raw_i != prev_q) begin
      prev_d   = raw_i;
      steady_d = '0;
    end else begin
      steady_d = bgdc_pkg::sat_inc(steady_q);
      if (raw_i != stable_q &&
          bgdc_pkg::cmp_t'(steady_d) >= bgdc_pkg::cmp_t'(cfg_i.debounce_ticks)) begin
        stable_d = raw_i;
        if (!raw_i) begin
          hold_d = '0;
          long_d = 1'b0;
        end else if (long_q) begin
          long_d = 1'b0;
        end else if (pending_q) begin
          if (bgdc_pkg::cmp_t'(pend_d) <= bgdc_pkg::cmp_t'(cfg_i.double_click_ticks)) begin
            digit_d   = bgdc_pkg::digit_down(digit_d);
            down      = 1'b1;
            pending_d = 1'b0;
          end else begin
            digit_d = bgdc_pkg::digit_up(digit_d);
            ups     = ups + 2'd1;
            pend_d  = '0;
          end
        end else begin
          pending_d = 1'b1;
          pend_d    = '0;
        end
      end
    end

    if (!stable_d) begin
      if (!long_d) begin
        if (bgdc_pkg::cmp_t'(hold_d) >= bgdc_pkg::cmp_t'(cfg_i.long_press_ticks)) begin
          digit_d = bgdc_pkg::digit_up(digit_d);
          ups     = ups + 2'd1;
          long_d  = 1'b1;
          rep_d   = '0;
        end
      end else if (bgdc_pkg::cmp_t'(rep_d) >= bgdc_pkg::cmp_t'(cfg_i.repeat_ticks)) begin
        digit_d = bgdc_pkg::digit_up(digit_d);
        ups     = ups + 2'd1;
        rep_d   = '0;
      end
    end

    if (pending_d &&
        bgdc_pkg::cmp_t'(pend_d) > bgdc_pkg::cmp_t'(cfg_i.double_click_ticks)) begin
      digit_d   = bgdc_pkg::digit_up(digit_d);
      ups       = ups + 2'd1;
      pending_d = 1'b0;
    end
  end

  always_comb begin
    res_o.digit = digit_d;
    res_o.seg   = bgdc_pkg::seg_of(digit_d) ^ {bgdc_pkg::SegW{cfg_i.common_anode}};
    if (down) begin
      res_o.code = bgdc_pkg::ChgMinusOne;
    end else begin
      case (ups)
        2'd0:    res_o.code = bgdc_pkg::ChgNone;
        2'd1:    res_o.code = bgdc_pkg::ChgPlusOne;
        default: res_o.code = bgdc_pkg::ChgPlusTwo;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= 1'b1;
      stable_q  <= 1'b1;
      long_q    <= 1'b0;
      pending_q <= 1'b0;
      steady_q  <= '0;
      hold_q    <= '0;
      rep_q     <= '0;
      pend_q    <= '0;
      digit_q   <= '0;
    end else if (en_i) begin
      prev_q    <= prev_d;
      stable_q  <= stable_d;
      long_q    <= long_d;
      pending_q <= pending_d;
      steady_q  <= steady_d;
      hold_q    <= hold_d;
      rep_q     <= rep_d;
      pend_q    <= pend_d;
      digit_q   <= digit_d;
    end
  end

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= bgdc_pkg::digit_t'(9))
    else $error("digit register left the decimal range");

  a_long_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_q |-> !stable_q)
    else $error("long press active while the button is released");

  a_raw_change_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && raw_i != prev_q) |=> (steady_q == '0))
    else $error("raw level change did not restart the steady count");

  a_down_clears_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.code == bgdc_pkg::ChgMinusOne) |=> !pending_q)
    else $error("double click left a click pending");

endmodule

>>> rtl/button_gesture_digit_counter_core.sv
// Top level of the button gesture digit counter: register port, item registers and engine.
// One raw button sample is taken per item and one result item is returned for each, at up to
// one item per clock cycle while out_stall_i does not hold a result. An accepted item waits in
// the input register, the whole state update is done combinationally as it moves on, and its
// result is offered from the result register, to be taken when out_stall_i is low.
// The input register can take a new item while a finished result waits. Configuration
// registers lie at byte addresses 0, 4, 8, 12 and 16 and are to be written only while no item
// is in flight.
module button_gesture_digit_counter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bgdc_pkg::AddrW-1:0] paddr,
  input  logic [bgdc_pkg::DataW-1:0] pwdata,
  output logic [bgdc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       raw_level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 digit_value_o,
  output logic [6:0]                 segment_bits_o,
  output logic [1:0]                 change_code_o
);

  bgdc_pkg::cfg_t cfg_q;
  bgdc_pkg::res_t res;
  bgdc_pkg::res_t res_q;
  bgdc_pkg::reg_idx_e reg_idx;
  logic in_valid_q;
  logic raw_q;
  logic out_valid_q;
  logic advance;
  logic cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = bgdc_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= bgdc_pkg::cfg_time_t'(5);
      cfg_q.double_click_ticks <= bgdc_pkg::cfg_time_t'(70);
      cfg_q.long_press_ticks   <= bgdc_pkg::cfg_time_t'(160);
      cfg_q.repeat_ticks       <= bgdc_pkg::cfg_time_t'(100);
      cfg_q.common_anode       <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bgdc_pkg::RegDebounce:    cfg_q.debounce_ticks     <= pwdata[11:0];
        bgdc_pkg::RegDoubleClick: cfg_q.double_click_ticks <= pwdata[11:0];
        bgdc_pkg::RegLongPress:   cfg_q.long_press_ticks   <= pwdata[11:0];
        bgdc_pkg::RegRepeat:      cfg_q.repeat_ticks       <= pwdata[11:0];
        bgdc_pkg::RegCommonAnode: cfg_q.common_anode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bgdc_pkg::RegDebounce:    prdata = bgdc_pkg::DataW'(cfg_q.debounce_ticks);
      bgdc_pkg::RegDoubleClick: prdata = bgdc_pkg::DataW'(cfg_q.double_click_ticks);
      bgdc_pkg::RegLongPress:   prdata = bgdc_pkg::DataW'(cfg_q.long_press_ticks);
      bgdc_pkg::RegRepeat:      prdata = bgdc_pkg::DataW'(cfg_q.repeat_ticks);
      bgdc_pkg::RegCommonAnode: prdata = bgdc_pkg::DataW'(cfg_q.common_anode);
      default:                  prdata = '0;
    endcase
  end

  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      raw_q <= raw_level_i;
    end
  end

  bgdc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .raw_i  (raw_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_value_o  = res_q.digit;
  assign segment_bits_o = res_q.seg;
  assign change_code_o  = res_q.code;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without an item waiting on both sides");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(res_q)))
    else $error("waiting result changed or vanished");

endmodule

>>> verif/tb.sv
// Testbench for the button gesture digit counter: gesture stimulus, tick prediction and checks.
`timescale 1ns / 100ps

module tb;

  localparam bgdc_pkg::seg_t DIGIT_GLYPH [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                                  7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bgdc_pkg::AddrW-1:0] paddr;
  logic [bgdc_pkg::DataW-1:0] pwdata;
  logic [bgdc_pkg::DataW-1:0] prdata;
  logic                       pready;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       raw_level_i = 1'b1;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [3:0]                 digit_value_o;
  logic [6:0]                 segment_bits_o;
  logic [1:0]                 change_code_o;

  button_gesture_digit_counter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_level_i    (raw_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_value_o  (digit_value_o),
    .segment_bits_o (segment_bits_o),
    .change_code_o  (change_code_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor configuration and state.
  bgdc_pkg::cfg_time_t db_ticks, dc_ticks, lp_ticks, rp_ticks;
  logic                anode;
  logic                prev_raw, stable_lvl, long_on, click_wait;
  bgdc_pkg::time_t     steady_cnt, hold_cnt, rep_cnt, click_age;
  bgdc_pkg::digit_t    count_digit;

  logic           raw_backlog [$];
  bgdc_pkg::res_t pending_readouts [$];
  int             queued_ticks;
  int             readouts_seen;
  int             mismatches;
  bit             src_gaps_on;
  bit             sink_stalls_on;
  logic           last_lvl;

  int             src_gap, next_gap;
  bgdc_pkg::res_t predicted;
  int             sink_hold, next_hold;
  bgdc_pkg::res_t want;

  function automatic bgdc_pkg::time_t bump(input bgdc_pkg::time_t v);
    return (&v) ? v : v + bgdc_pkg::time_t'(1);
  endfunction

  function automatic bgdc_pkg::digit_t wrap_up(input bgdc_pkg::digit_t d);
    return (d == bgdc_pkg::digit_t'(9)) ? bgdc_pkg::digit_t'(0) : d + bgdc_pkg::digit_t'(1);
  endfunction

  task automatic flag(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatches++;
  endtask

  task reset_model();
    db_ticks = bgdc_pkg::cfg_time_t'(5);
    dc_ticks = bgdc_pkg::cfg_time_t'(70);
    lp_ticks = bgdc_pkg::cfg_time_t'(160);
    rp_ticks = bgdc_pkg::cfg_time_t'(100);
    anode = 1'b0;
    prev_raw = 1'b1;
    stable_lvl = 1'b1;
    long_on = 1'b0;
    click_wait = 1'b0;
    steady_cnt = '0;
    hold_cnt = '0;
    rep_cnt = '0;
    click_age = '0;
    count_digit = '0;
  endtask

  task step_counter(input logic raw, output bgdc_pkg::res_t r);
    int            ups;
    logic          down;
    bgdc_pkg::seg_t glyph;
    ups = 0;
    down = 1'b0;
    hold_cnt = bump(hold_cnt);
    rep_cnt = bump(rep_cnt);
    click_age = bump(click_age);
    if (raw != prev_raw) begin
      prev_raw = raw;
      steady_cnt = '0;
    end else begin
      steady_cnt = bump(steady_cnt);
      if (raw != stable_lvl && steady_cnt >= db_ticks) begin
        stable_lvl = raw;
        if (!raw) begin
          hold_cnt = '0;
          long_on = 1'b0;
        end else if (long_on) begin
          long_on = 1'b0;
        end else if (click_wait) begin
          if (click_age <= dc_ticks) begin
            count_digit = (count_digit == bgdc_pkg::digit_t'(0)) ?
                          bgdc_pkg::digit_t'(9) : count_digit - bgdc_pkg::digit_t'(1);
            down = 1'b1;
            click_wait = 1'b0;
          end else begin
            count_digit = wrap_up(count_digit);
            ups++;
            click_age = '0;
          end
        end else begin
          click_wait = 1'b1;
          click_age = '0;
        end
      end
    end
    if (!stable_lvl) begin
      if (!long_on) begin
        if (hold_cnt >= lp_ticks) begin
          count_digit = wrap_up(count_digit);
          ups++;
          long_on = 1'b1;
          rep_cnt = '0;
        end
      end else if (rep_cnt >= rp_ticks) begin
        count_digit = wrap_up(count_digit);
        ups++;
        rep_cnt = '0;
      end
    end
    if (click_wait && click_age > dc_ticks) begin
      count_digit = wrap_up(count_digit);
      ups++;
      click_wait = 1'b0;
    end
    glyph = DIGIT_GLYPH[count_digit];
    if (anode) begin
      glyph = ~glyph;
    end
    r.digit = count_digit;
    r.seg = glyph;
    if (down) begin
      r.code = bgdc_pkg::ChgMinusOne;
    end else if (ups == 0) begin
      r.code = bgdc_pkg::ChgNone;
    end else if (ups == 1) begin
      r.code = bgdc_pkg::ChgPlusOne;
    end else begin
      r.code = bgdc_pkg::ChgPlusTwo;
    end
  endtask

  // Source side: one item per accepted tick, with a drawn gap after each one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      raw_level_i <= 1'b1;
      src_gap <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        step_counter(raw_level_i, predicted);
        pending_readouts.push_back(predicted);
        next_gap = src_gaps_on ? $urandom_range(0, 8) : 0;
      end else begin
        next_gap = (src_gap > 0) ? src_gap - 1 : 0;
      end
      if (next_gap == 0 && raw_backlog.size() != 0) begin
        in_valid_i <= 1'b1;
        raw_level_i <= raw_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
      src_gap <= next_gap;
    end
  end

  // Result side: checks each accepted item and draws the stall that follows it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        readouts_seen++;
        if (pending_readouts.size() == 0) begin
          flag($sformatf("result with no item outstanding, digit %0d", digit_value_o));
        end else begin
          want = pending_readouts.pop_front();
          if (digit_value_o !== want.digit) begin
            flag($sformatf("digit_value got %0d want %0d", digit_value_o, want.digit));
          end
          if (segment_bits_o !== want.seg) begin
            flag($sformatf("segment_bits got %h want %h", segment_bits_o, want.seg));
          end
          if (change_code_o !== want.code) begin
            flag($sformatf("change_code got %0d want %0d", change_code_o, want.code));
          end
        end
        if (readouts_seen % 700 == 350) begin
          next_hold = $urandom_range(60, 100);
        end else begin
          next_hold = sink_stalls_on ? $urandom_range(0, 8) : 0;
        end
      end else begin
        next_hold = (sink_hold > 0) ? sink_hold - 1 : 0;
      end
      sink_hold <= next_hold;
      out_stall_i <= (next_hold != 0);
    end
  end

  task apb_write(input bgdc_pkg::reg_idx_e idx, input logic [bgdc_pkg::DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bgdc_pkg::RegDebounce:    db_ticks = value[bgdc_pkg::CfgTimeW-1:0];
      bgdc_pkg::RegDoubleClick: dc_ticks = value[bgdc_pkg::CfgTimeW-1:0];
      bgdc_pkg::RegLongPress:   lp_ticks = value[bgdc_pkg::CfgTimeW-1:0];
      bgdc_pkg::RegRepeat:      rp_ticks = value[bgdc_pkg::CfgTimeW-1:0];
      bgdc_pkg::RegCommonAnode: anode = value[0];
      default: ;
    endcase
  endtask

  task set_config(input int db, input int dc, input int lp, input int rp, input int ca);
    apb_write(bgdc_pkg::RegDebounce, db);
    apb_write(bgdc_pkg::RegDoubleClick, dc);
    apb_write(bgdc_pkg::RegLongPress, lp);
    apb_write(bgdc_pkg::RegRepeat, rp);
    apb_write(bgdc_pkg::RegCommonAnode, ca);
    @(negedge clk_i);
    src_gaps_on = ($urandom_range(0, 3) != 0);
    sink_stalls_on = ($urandom_range(0, 3) != 0);
  endtask

  task hold_level(input logic lvl, input int n);
    repeat (n) begin
      raw_backlog.push_back(lvl);
      queued_ticks++;
    end
    last_lvl = lvl;
  endtask

  task await_idle();
    do @(negedge clk_i);
    while (raw_backlog.size() != 0 || in_valid_i || pending_readouts.size() != 0);
  endtask

  // Mostly well-formed presses sized from the current settings, with some bounce and noise.
  task add_gesture();
    int db, dc, lp, rp, k;
    db = int'(db_ticks);
    dc = int'(dc_ticks);
    lp = int'(lp_ticks);
    rp = int'(rp_ticks);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        hold_level(1'b0, db + 1 + $urandom_range(0, lp / 2 + 2));
        hold_level(1'b1, db + 1 + $urandom_range(0, 2 * dc + 6));
      end
      3, 4: begin
        repeat (2) begin
          hold_level(1'b0, db + 1 + $urandom_range(0, 3));
          hold_level(1'b1, db + 1 + $urandom_range(0, dc / 2 + 1));
        end
        hold_level(1'b1, $urandom_range(0, dc + 4));
      end
      5, 6: begin
        hold_level(1'b0, db + 1 + lp + $urandom_range(0, 3 * rp + 4));
        hold_level(1'b1, db + 1 + $urandom_range(0, 8));
      end
      7: begin
        k = $urandom_range(1, 5);
        repeat (k) hold_level(!last_lvl, $urandom_range(1, db + 1));
      end
      default: begin
        k = $urandom_range(1, 12);
        repeat (k) hold_level(1'($urandom_range(0, 1)), 1);
      end
    endcase
  endtask

  initial begin
    int phase_len;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    queued_ticks = 0;
    readouts_seen = 0;
    mismatches = 0;
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    last_lvl = 1'b1;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All periods zero: press starts the long press at once and repeats every tick.
    set_config(0, 0, 0, 0, 1);
    hold_level(1'b1, 1);
    hold_level(1'b0, 4);
    hold_level(1'b1, 3);
    await_idle();

    // Click, then a press whose long start meets the click expiry in the same tick.
    set_config(1, 3, 2, 1, 0);
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);
    hold_level(1'b0, 5);
    hold_level(1'b1, 2);
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);
    await_idle();

    // Longest settings; a short press stays below the debounce count and changes nothing.
    set_config(4095, 4095, 4095, 4095, 1);
    hold_level(1'b0, 40);
    hold_level(1'b1, 10);
    await_idle();

    while (queued_ticks < 1850) begin
      case ($urandom_range(0, 3))
        0: set_config(0, $urandom_range(0, 40), $urandom_range(0, 60), 1, 1);
        1: set_config(1, 0, $urandom_range(1, 10), $urandom_range(1, 5), $urandom_range(0, 1));
        2: set_config($urandom_range(2, 6), $urandom_range(5, 40), $urandom_range(10, 60),
                      $urandom_range(5, 30), $urandom_range(0, 1));
        default: set_config($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(0, 60),
                            $urandom_range(1, 30), $urandom_range(0, 1));
      endcase
      phase_len = queued_ticks + $urandom_range(100, 220);
      while (queued_ticks < phase_len) add_gesture();
      await_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
